### rtl/core/queue_depth_staleness_stats_top_assert.svh
// Assertion macros used by the checker file.
`ifndef QUEUE_DEPTH_STALENESS_STATS_TOP_ASSERT_SVH
`define QUEUE_DEPTH_STALENESS_STATS_TOP_ASSERT_SVH

// The consequent is checked in the cycle after the antecedent holds.
`define QDSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent is checked in the same cycle as the antecedent.
`define QDSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/qdss_pkg.sv
package qdss_pkg;

  localparam int BIN_W   = 6;
  localparam int DEPTH_W = 32;
  localparam int TIME_W  = 63;

  localparam logic OP_CHANGE = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_MERGE,
    ST_PREP,
    ST_FOLD,
    ST_EMIT
  } qdss_state_t;

  typedef struct packed {
    logic               op;
    logic [BIN_W-1:0]   bin;
    logic [DEPTH_W-1:0] depth;
    logic               is_multicast;
    logic               sweep_last;
    logic [TIME_W-1:0]  now_time;
  } qdss_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] shared;
    logic [DEPTH_W-1:0] hi;
    logic [DEPTH_W-1:0] lo;
  } qdss_entry_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] delta_a;
    logic [DEPTH_W-1:0] delta_b;
    logic [DEPTH_W-1:0] out_a;
    logic [DEPTH_W-1:0] out_b;
  } qdss_cand_t;

  typedef struct packed {
    logic mark_change;
    logic merge;
    logic prep;
    logic fold;
  } qdss_ctl_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] max_delta;
    logic [DEPTH_W-1:0] max_outside_range;
    logic [TIME_W-1:0]  max_stale_time;
    logic [DEPTH_W-1:0] total_delta;
    logic [DEPTH_W-1:0] total_outside_range;
    logic [TIME_W-1:0]  total_stale_time;
    logic [DEPTH_W-1:0] write_periods;
  } qdss_stats_t;

endpackage

### rtl/core/qdss_chan_if.sv
interface qdss_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [qdss_pkg::BIN_W-1:0]    bin;
  logic [qdss_pkg::DEPTH_W-1:0]  depth;
  logic                          is_multicast;
  logic                          sweep_last;
  logic [qdss_pkg::TIME_W-1:0]   now_time;

  modport source (output valid, op, bin, depth, is_multicast, sweep_last, now_time,
                  input ready);
  modport sink (input valid, op, bin, depth, is_multicast, sweep_last, now_time,
                output ready);
endinterface

interface qdss_out_if;
  logic                          valid;
  logic                          ready;
  logic [qdss_pkg::DEPTH_W-1:0]  max_delta;
  logic [qdss_pkg::DEPTH_W-1:0]  max_outside_range;
  logic [qdss_pkg::TIME_W-1:0]   max_stale_time;
  logic [qdss_pkg::DEPTH_W-1:0]  total_delta;
  logic [qdss_pkg::DEPTH_W-1:0]  total_outside_range;
  logic [qdss_pkg::TIME_W-1:0]   total_stale_time;
  logic [qdss_pkg::DEPTH_W-1:0]  write_periods;

  modport source (output valid, max_delta, max_outside_range, max_stale_time, total_delta,
                  total_outside_range, total_stale_time, write_periods,
                  input ready);
  modport sink (input valid, max_delta, max_outside_range, max_stale_time, total_delta,
                total_outside_range, total_stale_time, write_periods,
                output ready);
endinterface

### rtl/core/qdss_bin_store.sv
module qdss_bin_store #(
  parameter int MEM_DEPTH = 64,
  parameter int ADDR_W    = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output qdss_pkg::qdss_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  qdss_pkg::qdss_entry_t wr_data
);

  qdss_pkg::qdss_entry_t mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  vld_r;
  qdss_pkg::qdss_entry_t rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/core/qdss_stats.sv
module qdss_stats (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qdss_pkg::qdss_ctl_t               ctl,
  input  logic [qdss_pkg::TIME_W-1:0]       now_time,
  input  qdss_pkg::qdss_cand_t              cand,
  output logic                              pending,
  output qdss_pkg::qdss_stats_t             stats
);

  logic                           pending_r;
  logic [qdss_pkg::TIME_W-1:0]    first_r;
  logic [qdss_pkg::TIME_W-1:0]    last_wr_r;
  logic [qdss_pkg::DEPTH_W-1:0]   sw_delta_r;
  logic [qdss_pkg::DEPTH_W-1:0]   sw_out_r;
  logic [qdss_pkg::DEPTH_W-1:0]   peak_delta_r;
  logic [qdss_pkg::DEPTH_W-1:0]   peak_out_r;
  logic [qdss_pkg::TIME_W-1:0]    peak_stale_r;
  logic [qdss_pkg::DEPTH_W-1:0]   sum_delta_r;
  logic [qdss_pkg::DEPTH_W-1:0]   sum_out_r;
  logic [qdss_pkg::TIME_W-1:0]    sum_stale_r;
  logic [qdss_pkg::DEPTH_W-1:0]   periods_r;
  logic [qdss_pkg::TIME_W-1:0]    stale_r;
  logic [qdss_pkg::DEPTH_W:0]     dsum_r;
  logic [qdss_pkg::DEPTH_W:0]     osum_r;

  logic [qdss_pkg::DEPTH_W-1:0]   delta_pick;
  logic [qdss_pkg::DEPTH_W-1:0]   out_pick;
  logic [qdss_pkg::DEPTH_W-1:0]   sw_delta_nxt;
  logic [qdss_pkg::DEPTH_W-1:0]   sw_out_nxt;
  logic                           wrap;
  logic [qdss_pkg::TIME_W-1:0]    sum_stale_base;
  logic [qdss_pkg::DEPTH_W-1:0]   periods_base;

  always_comb begin
    delta_pick     = (cand.delta_a > cand.delta_b) ? cand.delta_a : cand.delta_b;
    out_pick       = (cand.out_a > cand.out_b) ? cand.out_a : cand.out_b;
    sw_delta_nxt   = (delta_pick > sw_delta_r) ? delta_pick : sw_delta_r;
    sw_out_nxt     = (out_pick > sw_out_r) ? out_pick : sw_out_r;
    // A carry out of either running total clears all totals before the add.
    wrap           = dsum_r[qdss_pkg::DEPTH_W] | osum_r[qdss_pkg::DEPTH_W];
    sum_stale_base = wrap ? '0 : sum_stale_r;
    periods_base   = wrap ? '0 : periods_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= 1'b0;
      first_r      <= '0;
      last_wr_r    <= '0;
      sw_delta_r   <= '0;
      sw_out_r     <= '0;
      peak_delta_r <= '0;
      peak_out_r   <= '0;
      peak_stale_r <= '0;
      sum_delta_r  <= '0;
      sum_out_r    <= '0;
      sum_stale_r  <= '0;
      periods_r    <= '0;
      stale_r      <= '0;
      dsum_r       <= '0;
      osum_r       <= '0;
    end else begin
      if (ctl.mark_change && !pending_r) begin
        pending_r <= 1'b1;
        first_r   <= now_time;
      end
      if (ctl.merge) begin
        sw_delta_r <= sw_delta_nxt;
        sw_out_r   <= sw_out_nxt;
      end
      if (ctl.prep) begin
        stale_r <= first_r - last_wr_r;
        dsum_r  <= {1'b0, sum_delta_r} + {1'b0, sw_delta_r};
        osum_r  <= {1'b0, sum_out_r} + {1'b0, sw_out_r};
      end
      if (ctl.fold) begin
        last_wr_r <= now_time;
        if (pending_r) begin
          if (sw_delta_r > peak_delta_r) begin
            peak_delta_r <= sw_delta_r;
          end
          if (sw_out_r > peak_out_r) begin
            peak_out_r <= sw_out_r;
          end
          if (stale_r > peak_stale_r) begin
            peak_stale_r <= stale_r;
          end
          sum_delta_r <= wrap ? sw_delta_r : dsum_r[qdss_pkg::DEPTH_W-1:0];
          sum_out_r   <= wrap ? sw_out_r : osum_r[qdss_pkg::DEPTH_W-1:0];
          sum_stale_r <= sum_stale_base + stale_r;
          periods_r   <= periods_base + 1'b1;
          sw_delta_r  <= '0;
          sw_out_r    <= '0;
          pending_r   <= 1'b0;
        end else begin
          periods_r <= periods_r + 1'b1;
        end
      end
    end
  end

  assign pending                   = pending_r;
  assign stats.max_delta           = peak_delta_r;
  assign stats.max_outside_range   = peak_out_r;
  assign stats.max_stale_time      = peak_stale_r;
  assign stats.total_delta         = sum_delta_r;
  assign stats.total_outside_range = sum_out_r;
  assign stats.total_stale_time    = sum_stale_r;
  assign stats.write_periods       = periods_r;

endmodule

### rtl/core/queue_depth_staleness_stats_top.sv
// A result is registered on the output after its transaction passes the modify, merge
// and emit states; one that ends a snapshot sweep also passes prep and fold. A stalled
// output holds the result back. One transaction is in flight at a time; the bin memory
// read, the modify and write-back, the merge and the sweep-end fold run one at a time.
// Reset (synchronous, active low) clears the bin valid bits so every bin reads zero,
// and clears all statistics; the block accepts a transaction in the first cycle after.
module queue_depth_staleness_stats_top #(
  parameter int NUM_BINS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  qdss_in_if.sink    in_chan,
  qdss_out_if.source out_chan
);

  localparam int BIN_SPAN  = 1 << qdss_pkg::BIN_W;
  localparam int MEM_DEPTH = (NUM_BINS < BIN_SPAN) ? NUM_BINS : BIN_SPAN;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  qdss_pkg::qdss_state_t state_r;
  qdss_pkg::qdss_state_t state_nxt;
  qdss_pkg::qdss_item_t  item_r;
  qdss_pkg::qdss_cand_t  cand_r;
  qdss_pkg::qdss_cand_t  cand_nxt;
  qdss_pkg::qdss_ctl_t   ctl;
  qdss_pkg::qdss_stats_t stats;
  qdss_pkg::qdss_stats_t out_r;
  logic                  out_valid_r;

  logic                  accept;
  logic                  emit;
  logic                  pending;
  logic                  hit;
  logic                  counted;
  qdss_pkg::qdss_entry_t rd_entry;
  qdss_pkg::qdss_entry_t wr_entry;
  logic                  wr_en;
  logic [qdss_pkg::DEPTH_W-1:0] newv;
  logic [qdss_pkg::DEPTH_W-1:0] rmax;
  logic [qdss_pkg::DEPTH_W-1:0] rmin;

  assign accept = in_chan.valid && in_chan.ready;

  qdss_bin_store #(
    .MEM_DEPTH (MEM_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(in_chan.bin)),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(item_r.bin)),
    .wr_data (wr_entry)
  );

  qdss_stats u_stats (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .now_time (item_r.now_time),
    .cand     (cand_r),
    .pending  (pending),
    .stats    (stats)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qdss_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = qdss_pkg::ST_MODIFY;
        end
      end
      qdss_pkg::ST_MODIFY: state_nxt = qdss_pkg::ST_MERGE;
      qdss_pkg::ST_MERGE: begin
        if (item_r.op == qdss_pkg::OP_SWEEP && item_r.sweep_last) begin
          state_nxt = qdss_pkg::ST_PREP;
        end else begin
          state_nxt = qdss_pkg::ST_EMIT;
        end
      end
      qdss_pkg::ST_PREP: state_nxt = qdss_pkg::ST_FOLD;
      qdss_pkg::ST_FOLD: state_nxt = qdss_pkg::ST_EMIT;
      qdss_pkg::ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = qdss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qdss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready   = 1'b0;
    ctl             = '0;
    emit            = 1'b0;
    unique case (state_r)
      qdss_pkg::ST_IDLE:   in_chan.ready   = rst_n;
      qdss_pkg::ST_MODIFY: ctl.mark_change = (item_r.op == qdss_pkg::OP_CHANGE);
      qdss_pkg::ST_MERGE:  ctl.merge       = 1'b1;
      qdss_pkg::ST_PREP:   ctl.prep        = 1'b1;
      qdss_pkg::ST_FOLD:   ctl.fold        = 1'b1;
      qdss_pkg::ST_EMIT:   emit            = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // Bin update: a change widens the bin's range, a counted sweep item measures the
  // excursions and restarts the bin at its new shared value.
  always_comb begin
    hit      = 32'(item_r.bin) < NUM_BINS;
    counted  = pending && hit;
    newv     = item_r.is_multicast ? '0 : item_r.depth;
    rmax     = (rd_entry.shared > newv) ? rd_entry.shared : newv;
    rmin     = (rd_entry.shared > newv) ? newv : rd_entry.shared;
    cand_nxt = '0;
    wr_entry = rd_entry;
    wr_en    = 1'b0;
    if (state_r == qdss_pkg::ST_MODIFY) begin
      if (item_r.op == qdss_pkg::OP_CHANGE) begin
        wr_en = hit;
        if (item_r.depth > rd_entry.hi) begin
          wr_entry.hi = item_r.depth;
        end
        if (item_r.depth < rd_entry.lo) begin
          wr_entry.lo = item_r.depth;
        end
      end else if (counted) begin
        wr_en    = 1'b1;
        wr_entry = '{shared: newv, hi: newv, lo: newv};
        if (rd_entry.hi > rd_entry.shared) begin
          cand_nxt.delta_a = rd_entry.hi - rd_entry.shared;
        end
        if (rd_entry.lo < rd_entry.shared) begin
          cand_nxt.delta_b = rd_entry.shared - rd_entry.lo;
        end
        if (rd_entry.hi > rmax) begin
          cand_nxt.out_a = rd_entry.hi - rmax;
        end
        if (rd_entry.lo < rmin) begin
          cand_nxt.out_b = rmin - rd_entry.lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{op: in_chan.op, bin: in_chan.bin, depth: in_chan.depth,
                  is_multicast: in_chan.is_multicast, sweep_last: in_chan.sweep_last,
                  now_time: in_chan.now_time};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qdss_pkg::ST_IDLE;
      cand_r      <= '0;
      out_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == qdss_pkg::ST_MODIFY) begin
        cand_r <= cand_nxt;
      end
      if (emit) begin
        out_r       <= stats;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.max_delta           = out_r.max_delta;
  assign out_chan.max_outside_range   = out_r.max_outside_range;
  assign out_chan.max_stale_time      = out_r.max_stale_time;
  assign out_chan.total_delta         = out_r.total_delta;
  assign out_chan.total_outside_range = out_r.total_outside_range;
  assign out_chan.total_stale_time    = out_r.total_stale_time;
  assign out_chan.write_periods       = out_r.write_periods;

endmodule

### rtl/core/qdss_checker.sv
`include "queue_depth_staleness_stats_top_assert.svh"

module qdss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [qdss_pkg::DEPTH_W-1:0] out_max_delta,
  input logic [qdss_pkg::DEPTH_W-1:0] out_total_delta,
  input logic [qdss_pkg::TIME_W-1:0]  out_max_stale_time,
  input logic [qdss_pkg::DEPTH_W-1:0] out_write_periods
);

  // One transaction is in flight at a time.
  `QDSS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted while busy")

  `QDSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_total_delta) && $stable(out_write_periods),
                    "stalled result changed")

  // Peaks never shrink from one result to the next.
  `QDSS_ASSERT_NOW(a_peak_mono, $past(rst_n),
                   out_max_delta >= $past(out_max_delta) &&
                   out_max_stale_time >= $past(out_max_stale_time),
                   "peak decreased")

  // The write counter steps by one per sweep end or restarts at one after a clear.
  `QDSS_ASSERT_NOW(a_period_step, $past(rst_n) && !$stable(out_write_periods),
                   out_write_periods == $past(out_write_periods) + 32'd1 ||
                   out_write_periods == 32'd1,
                   "write count jumped")

endmodule

bind queue_depth_staleness_stats_top qdss_checker u_qdss_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_max_delta      (out_chan.max_delta),
  .out_total_delta    (out_chan.total_delta),
  .out_max_stale_time (out_chan.max_stale_time),
  .out_write_periods  (out_chan.write_periods)
);

### sim/queue_depth_staleness_stats_top_tb.sv
`timescale 1ns / 1ps

module queue_depth_staleness_stats_top_tb;

  localparam int BINS = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_PCT = 27;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 450;

  class staleness_scoreboard;
    bit [qdss_pkg::DEPTH_W-1:0] shared_depth [BINS];
    bit [qdss_pkg::DEPTH_W-1:0] high_mark [BINS];
    bit [qdss_pkg::DEPTH_W-1:0] low_mark [BINS];
    bit change_seen;
    bit [qdss_pkg::TIME_W-1:0] first_stamp;
    bit [qdss_pkg::TIME_W-1:0] last_stamp;
    bit [qdss_pkg::DEPTH_W-1:0] sweep_dev;
    bit [qdss_pkg::DEPTH_W-1:0] sweep_exc;
    qdss_pkg::qdss_stats_t stats;
    qdss_pkg::qdss_stats_t expected_q[$];
    int errors;
    int checked;
    int clears;
    int sweeps_done;

    function new();
      stats = '0;
    endfunction

    function void note_item(qdss_pkg::qdss_item_t it);
      bit [qdss_pkg::DEPTH_W-1:0] nv;
      bit [qdss_pkg::DEPTH_W-1:0] old;
      bit [qdss_pkg::DEPTH_W-1:0] hi;
      bit [qdss_pkg::DEPTH_W-1:0] lo;
      bit [qdss_pkg::DEPTH_W-1:0] rmax;
      bit [qdss_pkg::DEPTH_W-1:0] rmin;
      bit [qdss_pkg::TIME_W-1:0] stale;
      if (it.op == qdss_pkg::OP_CHANGE) begin
        if (it.bin < BINS) begin
          if (it.depth > high_mark[it.bin]) high_mark[it.bin] = it.depth;
          if (it.depth < low_mark[it.bin]) low_mark[it.bin] = it.depth;
        end
        if (!change_seen) begin
          change_seen = 1'b1;
          first_stamp = it.now_time;
        end
      end else begin
        if (change_seen && it.bin < BINS) begin
          nv = it.is_multicast ? '0 : it.depth;
          old = shared_depth[it.bin];
          hi = high_mark[it.bin];
          lo = low_mark[it.bin];
          rmax = (old > nv) ? old : nv;
          rmin = (old > nv) ? nv : old;
          if (hi > old && hi - old > sweep_dev) sweep_dev = hi - old;
          if (lo < old && old - lo > sweep_dev) sweep_dev = old - lo;
          if (hi > rmax && hi - rmax > sweep_exc) sweep_exc = hi - rmax;
          if (lo < rmin && rmin - lo > sweep_exc) sweep_exc = rmin - lo;
          shared_depth[it.bin] = nv;
          high_mark[it.bin] = nv;
          low_mark[it.bin] = nv;
        end
        if (it.sweep_last) begin
          if (change_seen) begin
            stale = first_stamp - last_stamp;
            if (sweep_dev > stats.max_delta) stats.max_delta = sweep_dev;
            if (sweep_exc > stats.max_outside_range) stats.max_outside_range = sweep_exc;
            if (stale > stats.max_stale_time) stats.max_stale_time = stale;
            // The totals restart rather than wrap when either sum would overflow.
            if ((32'hFFFF_FFFF - sweep_dev) < stats.total_delta ||
                (32'hFFFF_FFFF - sweep_exc) < stats.total_outside_range) begin
              stats.total_delta = '0;
              stats.total_outside_range = '0;
              stats.total_stale_time = '0;
              stats.write_periods = '0;
              clears++;
            end
            stats.total_delta = stats.total_delta + sweep_dev;
            stats.total_outside_range = stats.total_outside_range + sweep_exc;
            stats.total_stale_time = stats.total_stale_time + stale;
            sweep_dev = '0;
            sweep_exc = '0;
            change_seen = 1'b0;
          end
          last_stamp = it.now_time;
          stats.write_periods = stats.write_periods + 32'd1;
          sweeps_done++;
        end
      end
      expected_q.push_back(stats);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                  checked, name, got, want));
    endtask

    task check_result(qdss_pkg::qdss_stats_t got);
      qdss_pkg::qdss_stats_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction arrived with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("max_delta", 64'(got.max_delta), 64'(want.max_delta));
      compare_field("max_outside_range", 64'(got.max_outside_range),
                    64'(want.max_outside_range));
      compare_field("max_stale_time", 64'(got.max_stale_time), 64'(want.max_stale_time));
      compare_field("total_delta", 64'(got.total_delta), 64'(want.total_delta));
      compare_field("total_outside_range", 64'(got.total_outside_range),
                    64'(want.total_outside_range));
      compare_field("total_stale_time", 64'(got.total_stale_time),
                    64'(want.total_stale_time));
      compare_field("write_periods", 64'(got.write_periods), 64'(want.write_periods));
    endtask
  endclass

  logic clk;
  logic rst_n;
  qdss_in_if in_chan();
  qdss_out_if out_chan();
  staleness_scoreboard stats_board = new();

  int items_sent;
  int changes_sent;
  int sweep_items_sent;
  bit quiet_in;
  bit quiet_out;
  bit [qdss_pkg::TIME_W-1:0] clock_us;

  queue_depth_staleness_stats_top #(.NUM_BINS(BINS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Timeout with %0d results still expected", stats_board.expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int hold_left;
    bit pressure_done;
    qdss_pkg::qdss_stats_t got;
    hold_left = 0;
    pressure_done = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.max_delta = out_chan.max_delta;
        got.max_outside_range = out_chan.max_outside_range;
        got.max_stale_time = out_chan.max_stale_time;
        got.total_delta = out_chan.total_delta;
        got.total_outside_range = out_chan.total_outside_range;
        got.total_stale_time = out_chan.total_stale_time;
        got.write_periods = out_chan.write_periods;
        stats_board.check_result(got);
      end
      if (!pressure_done && stats_board.checked >= HOLD_AFTER) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= quiet_out || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer(input logic op, input int bin,
                       input logic [qdss_pkg::DEPTH_W-1:0] depth,
                       input logic mc, input logic last,
                       input logic [qdss_pkg::TIME_W-1:0] stamp);
    qdss_pkg::qdss_item_t it;
    int gap;
    it.op = op;
    it.bin = bin[qdss_pkg::BIN_W-1:0];
    it.depth = depth;
    it.is_multicast = mc;
    it.sweep_last = last;
    it.now_time = stamp;
    gap = 0;
    if (!quiet_in) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.op <= it.op;
    in_chan.bin <= it.bin;
    in_chan.depth <= it.depth;
    in_chan.is_multicast <= it.is_multicast;
    in_chan.sweep_last <= it.sweep_last;
    in_chan.now_time <= it.now_time;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    stats_board.note_item(it);
    items_sent++;
    if (op == qdss_pkg::OP_CHANGE) changes_sent++;
    else sweep_items_sent++;
  endtask

  function automatic logic [qdss_pkg::TIME_W-1:0] next_stamp();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if ($urandom_range(99) < 4) clock_us = raw[qdss_pkg::TIME_W-1:0];
    else clock_us = clock_us + $urandom_range(1, 1000);
    return clock_us;
  endfunction

  function automatic logic [qdss_pkg::DEPTH_W-1:0] pick_depth(int bin);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      4, 5, 6: return stats_board.shared_depth[bin] + $urandom_range(0, 64) - 32;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    int random_start;
    int done;
    int kind;
    int base;
    int n_chg;
    int n_sw;
    int b;
    in_chan.valid <= 1'b0;
    in_chan.op <= qdss_pkg::OP_CHANGE;
    in_chan.bin <= '0;
    in_chan.depth <= '0;
    in_chan.is_multicast <= 1'b0;
    in_chan.sweep_last <= 1'b0;
    in_chan.now_time <= '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sweep end with no change pending, then extreme depths and a multicast bin.
    offer(qdss_pkg::OP_SWEEP, 5, 7, 1'b0, 1'b1, 100);
    offer(qdss_pkg::OP_CHANGE, 0, '1, 1'b0, 1'b0, 200);
    offer(qdss_pkg::OP_CHANGE, 63, 32'h8000_0000, 1'b1, 1'b1, 210);
    offer(qdss_pkg::OP_CHANGE, 63, '0, 1'b0, 1'b0, 220);
    offer(qdss_pkg::OP_SWEEP, 0, 32'h1234_5678, 1'b1, 1'b0, 300);
    offer(qdss_pkg::OP_SWEEP, 63, 32'h7FFF_FFFF, 1'b0, 1'b0, 301);
    offer(qdss_pkg::OP_SWEEP, 1, 5, 1'b0, 1'b1, '1);
    offer(qdss_pkg::OP_SWEEP, 2, 9, 1'b0, 1'b0, 400);
    offer(qdss_pkg::OP_SWEEP, 3, 11, 1'b1, 1'b1, 401);
    // A change arrives in the middle of a sweep, with a stamp older than the last write.
    offer(qdss_pkg::OP_SWEEP, 4, 100, 1'b0, 1'b0, 500);
    offer(qdss_pkg::OP_CHANGE, 4, 50, 1'b0, 1'b0, 5);
    offer(qdss_pkg::OP_SWEEP, 4, 80, 1'b0, 1'b0, 501);
    offer(qdss_pkg::OP_SWEEP, 5, 3, 1'b1, 1'b1, 6);
    // Full-scale deltas force the totals to restart.
    offer(qdss_pkg::OP_CHANGE, 10, '1, 1'b0, 1'b0, 600);
    offer(qdss_pkg::OP_SWEEP, 10, '0, 1'b0, 1'b1, 601);
    offer(qdss_pkg::OP_CHANGE, 10, 1, 1'b0, 1'b0, 602);
    offer(qdss_pkg::OP_SWEEP, 10, '1, 1'b0, 1'b1, 603);
    offer(qdss_pkg::OP_CHANGE, 20, 32'h5555_5555, 1'b0, 1'b0, 700);
    offer(qdss_pkg::OP_SWEEP, 20, 32'hAAAA_AAAA, 1'b0, 1'b1, 701);

    clock_us = 1000;
    random_start = items_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      quiet_in = (done >= 700 && done < 900);
      quiet_out = quiet_in;
      kind = $urandom_range(99);
      base = $urandom_range(0, BINS - 1);
      if (kind < 70) begin
        n_chg = $urandom_range(1, 6);
        n_sw = $urandom_range(1, 5);
        for (int i = 0; i < n_chg; i++) begin
          b = (base + $urandom_range(0, n_sw - 1)) % BINS;
          offer(qdss_pkg::OP_CHANGE, b, pick_depth(b), 1'($urandom_range(1)),
                1'($urandom_range(1)), next_stamp());
        end
        for (int i = 0; i < n_sw; i++) begin
          b = (base + i) % BINS;
          if ($urandom_range(9) == 0)
            offer(qdss_pkg::OP_CHANGE, b, pick_depth(b), 1'b0, 1'b0, next_stamp());
          offer(qdss_pkg::OP_SWEEP, b, pick_depth(b), $urandom_range(99) < 15,
                i == n_sw - 1, next_stamp());
        end
      end else if (kind < 71) begin
        offer(qdss_pkg::OP_CHANGE, base, pick_depth(base), 1'b0, 1'b0, next_stamp());
        for (int i = 0; i < BINS; i++)
          offer(qdss_pkg::OP_SWEEP, i, pick_depth(i), $urandom_range(99) < 15,
                i == BINS - 1, next_stamp());
      end else if (kind < 85) begin
        n_sw = $urandom_range(1, 4);
        for (int i = 0; i < n_sw; i++)
          offer(qdss_pkg::OP_SWEEP, (base + i) % BINS, $urandom, 1'($urandom_range(1)),
                i == n_sw - 1, next_stamp());
      end else begin
        n_chg = $urandom_range(1, 4);
        for (int i = 0; i < n_chg; i++)
          offer(1'($urandom_range(1)), $urandom_range(0, BINS - 1), $urandom,
                1'($urandom_range(1)), 1'($urandom_range(1)), next_stamp());
      end
      done = items_sent - random_start;
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    in_chan.valid <= 1'b0;

    while (stats_board.expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions: %0d depth changes and %0d sweep items.",
             items_sent, changes_sent, sweep_items_sent);
    $display("Checked %0d results over %0d sweeps, with %0d restarts of the totals.",
             stats_board.checked, stats_board.sweeps_done, stats_board.clears);
    if (stats_board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/qdss_pkg.sv
rtl/core/qdss_chan_if.sv
rtl/core/qdss_bin_store.sv
rtl/core/qdss_stats.sv
rtl/core/queue_depth_staleness_stats_top.sv
rtl/core/qdss_checker.sv
sim/queue_depth_staleness_stats_top_tb.sv
